// File: design/ipdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdm_pkg
// Shared types, constants and helpers for the interpolating PDM modulator.
// ----------------------------------------------------------------------------
package ipdm_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int LEVEL_W       = 22;
  localparam int PDM_W         = 64;
  localparam int RATIO_MAX     = 64;
  localparam int DEFAULT_RATIO = 64;
  localparam int DQ_W          = LEVEL_W + 1;
  localparam int DR_W          = $clog2(RATIO_MAX);
  localparam int ACC_W         = 32;

  typedef logic [LEVEL_W-1:0] level_t;

  typedef struct packed {
    level_t                  a;
    logic signed [DQ_W-1:0]  dq;
    logic [DR_W-1:0]         dr;
    logic                    eos;
  } job_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH_INTERP,
    FE_PUSH_FLAT
  } fe_state_t;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_RUN,
    BE_HOLD
  } be_state_t;

  // offset binary, scaled by 64
  function automatic level_t level_of(input logic [SAMPLE_W-1:0] s);
    level_of = {~s[SAMPLE_W-1], s[SAMPLE_W-2:0], 6'b0};
  endfunction

endpackage

// File: design/interpolating_pdm_modulator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Words: R = UPSAMPLE_RATIO bits each; a lone last sample gives only its flat
//   end word, and any other last sample is followed by a flat end word.
// Rate: the modulator loop makes one bit per cycle while it runs, holding when
//   the output register is busy; the front end runs ahead via the job queue.
// Reset: synchronous active-low rst_n clears held sample, integrators,
//   quantizer, job queue and output valid; ready in the first cycle after.
// ----------------------------------------------------------------------------
// interpolating_pdm_modulator_core
// Linear interpolator feeding a second-order one-bit delta-sigma modulator,
// bits packed one word per sample interval.
// ----------------------------------------------------------------------------
module interpolating_pdm_modulator_core #(
  parameter int UPSAMPLE_RATIO = ipdm_pkg::DEFAULT_RATIO
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ipdm_pkg::SAMPLE_W-1:0] in_tdata,   // [15:0] sample
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ipdm_pkg::PDM_W-1:0]    out_tdata,  // [63:0] pdm_bits
  output logic                          out_tlast
);

  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  ipdm_pkg::job_t push_data;
  ipdm_pkg::job_t pop_data;

  ipdm_front #(
    .UPSAMPLE_RATIO(UPSAMPLE_RATIO)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  ipdm_job_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  ipdm_back #(
    .UPSAMPLE_RATIO(UPSAMPLE_RATIO)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop        (pop),
    .pop_data   (pop_data),
    .empty      (empty),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: design/ipdm_job_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdm_job_fifo
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module ipdm_job_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ipdm_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output ipdm_pkg::job_t pop_data,
  output logic          empty
);

  ipdm_pkg::job_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/ipdm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdm_front
// Accepts samples, tracks the held sample and builds modulator jobs; the
// per-bit interpolation step (b - a) / R comes from a reciprocal multiply.
// ----------------------------------------------------------------------------
module ipdm_front #(
  parameter int UPSAMPLE_RATIO = ipdm_pkg::DEFAULT_RATIO
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ipdm_pkg::SAMPLE_W-1:0] in_tdata,
  input  logic                          in_tlast,
  output logic                          push,
  output ipdm_pkg::job_t                push_data,
  input  logic                          full
);

  localparam int R_W   = $clog2(UPSAMPLE_RATIO);
  localparam int X_W   = ipdm_pkg::LEVEL_W + R_W + 1;
  localparam int K_SH  = X_W + R_W;
  localparam int M_W   = X_W + 1;
  localparam int P_W   = X_W + M_W;
  localparam longint MAGIC_L = ((longint'(1) << K_SH) + longint'(UPSAMPLE_RATIO) - 1) /
                               longint'(UPSAMPLE_RATIO);
  localparam logic [M_W-1:0] MAGIC  = M_W'(MAGIC_L);
  localparam logic [X_W-1:0] OFFSET = X_W'(UPSAMPLE_RATIO) << ipdm_pkg::LEVEL_W;
  localparam logic [X_W-1:0] RATIO  = X_W'(UPSAMPLE_RATIO);

  ipdm_pkg::fe_state_t state_r, state_nxt;
  logic [ipdm_pkg::SAMPLE_W-1:0] held_r, held_nxt;
  logic                          have_held_r, have_held_nxt;
  logic                          last_r, last_nxt;
  ipdm_pkg::level_t              a_r, a_nxt;
  ipdm_pkg::level_t              b_r, b_nxt;
  logic [X_W-1:0]                x_r, x_nxt;
  logic [ipdm_pkg::DQ_W-1:0]     quo_r, quo_nxt;
  logic [P_W-1:0]                prod;
  logic [X_W-1:0]                quo_mul;
  logic [X_W-1:0]                rem_full;
  ipdm_pkg::level_t              in_level;
  ipdm_pkg::level_t              held_level;

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    have_held_nxt = have_held_r;
    last_nxt      = last_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    x_nxt         = x_r;
    quo_nxt       = quo_r;
    in_tready     = 1'b0;
    push          = 1'b0;
    in_level      = ipdm_pkg::level_of(in_tdata);
    held_level    = ipdm_pkg::level_of(held_r);
    prod          = P_W'(x_r) * P_W'(MAGIC);
    quo_mul       = X_W'(quo_r) * RATIO;
    rem_full      = x_r - quo_mul;
    push_data.a   = b_r;
    push_data.dq  = '0;
    push_data.dr  = '0;
    push_data.eos = 1'b1;

    unique case (state_r)
      ipdm_pkg::FE_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          held_nxt      = in_tdata;
          have_held_nxt = !in_tlast;
          last_nxt      = in_tlast;
          a_nxt         = held_level;
          b_nxt         = in_level;
          if (have_held_r) begin
            x_nxt     = OFFSET + X_W'(in_level) - X_W'(held_level);
            state_nxt = ipdm_pkg::FE_DIV;
          end else if (in_tlast) begin
            state_nxt = ipdm_pkg::FE_PUSH_FLAT;
          end
        end
      end
      ipdm_pkg::FE_DIV: begin
        quo_nxt   = prod[K_SH +: ipdm_pkg::DQ_W];
        state_nxt = ipdm_pkg::FE_PUSH_INTERP;
      end
      ipdm_pkg::FE_PUSH_INTERP: begin
        push          = 1'b1;
        push_data.a   = a_r;
        // quotient carries a 2^22 bias; flipping its top bit removes it
        push_data.dq  = {~quo_r[ipdm_pkg::DQ_W-1], quo_r[ipdm_pkg::DQ_W-2:0]};
        push_data.dr  = ipdm_pkg::DR_W'(rem_full[R_W-1:0]);
        push_data.eos = 1'b0;
        if (!full) begin
          state_nxt = last_r ? ipdm_pkg::FE_PUSH_FLAT : ipdm_pkg::FE_IDLE;
        end
      end
      ipdm_pkg::FE_PUSH_FLAT: begin
        push = 1'b1;
        if (!full) begin
          state_nxt = ipdm_pkg::FE_IDLE;
        end
      end
      default: begin
        state_nxt = ipdm_pkg::FE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ipdm_pkg::FE_IDLE;
      held_r      <= '0;
      have_held_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      have_held_r <= have_held_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    x_r   <= x_nxt;
    quo_r <= quo_nxt;
  end

endmodule

// File: design/ipdm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdm_back
// Second-order one-bit delta-sigma loop, one bit per cycle in BE_RUN, with the
// linear interpolator stepped alongside and an output register to the sink.
// ----------------------------------------------------------------------------
module ipdm_back #(
  parameter int UPSAMPLE_RATIO = ipdm_pkg::DEFAULT_RATIO
) (
  input  logic                       clk,
  input  logic                       rst_n,
  output logic                       pop,
  input  ipdm_pkg::job_t             pop_data,
  input  logic                       empty,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [ipdm_pkg::PDM_W-1:0] out_tdata,
  output logic                       out_tlast
);

  localparam int R_W   = $clog2(UPSAMPLE_RATIO);
  localparam int REM_W = R_W + 1;
  localparam int SUM_W = ipdm_pkg::ACC_W + 2;
  localparam int V_W   = ipdm_pkg::LEVEL_W + 2;
  localparam logic [REM_W-1:0] DIVISOR = REM_W'(UPSAMPLE_RATIO);
  localparam logic [SUM_W-1:0] UNIT    = SUM_W'(1) << ipdm_pkg::LEVEL_W;

  ipdm_pkg::be_state_t state_r, state_nxt;
  logic signed [ipdm_pkg::ACC_W-1:0] inner_r, inner_nxt;
  logic signed [ipdm_pkg::ACC_W-1:0] outer_r, outer_nxt;
  logic                              q_r, q_nxt;
  ipdm_pkg::level_t                  v_r, v_nxt;
  logic [R_W-1:0]                    rem_r, rem_nxt;
  logic signed [ipdm_pkg::DQ_W-1:0]  dq_r, dq_nxt;
  logic [R_W-1:0]                    dr_r, dr_nxt;
  logic                              eos_r, eos_nxt;
  logic [R_W-1:0]                    cnt_r, cnt_nxt;
  logic [UPSAMPLE_RATIO-1:0]         sh_r, sh_nxt;
  logic                              ov_r, ov_nxt;
  logic [ipdm_pkg::PDM_W-1:0]        od_r, od_nxt;
  logic                              ol_r, ol_nxt;

  logic [SUM_W-1:0]                  fb;
  logic [SUM_W-1:0]                  inner_sum, outer_sum;
  logic signed [ipdm_pkg::ACC_W-1:0] inner_sat, outer_sat;
  logic                              bit_q;
  logic [REM_W-1:0]                  rem_sum, rem_sub;
  logic                              carry;
  logic [V_W-1:0]                    v_sum;
  logic                              out_free;

  function automatic logic signed [ipdm_pkg::ACC_W-1:0] sat(input logic [SUM_W-1:0] s);
    if (!s[SUM_W-1] && (s[SUM_W-2:ipdm_pkg::ACC_W-1] != '0)) begin
      sat = {1'b0, {(ipdm_pkg::ACC_W-1){1'b1}}};
    end else if (s[SUM_W-1] && (s[SUM_W-2:ipdm_pkg::ACC_W-1] != '1)) begin
      sat = {1'b1, {(ipdm_pkg::ACC_W-1){1'b0}}};
    end else begin
      sat = s[ipdm_pkg::ACC_W-1:0];
    end
  endfunction

  always_comb begin
    fb        = q_r ? UNIT : '0;
    inner_sum = SUM_W'(inner_r) + SUM_W'(v_r) - fb;
    inner_sat = sat(inner_sum);
    outer_sum = SUM_W'(outer_r) + SUM_W'(inner_sat) - fb;
    outer_sat = sat(outer_sum);
    bit_q     = !outer_sat[ipdm_pkg::ACC_W-1];
    rem_sum   = REM_W'(rem_r) + REM_W'(dr_r);
    rem_sub   = rem_sum - DIVISOR;
    carry     = (rem_sum >= DIVISOR);
    v_sum     = V_W'(v_r) + V_W'(dq_r) + V_W'(carry);
    out_free  = !ov_r || out_tready;
  end

  always_comb begin
    state_nxt = state_r;
    inner_nxt = inner_r;
    outer_nxt = outer_r;
    q_nxt     = q_r;
    v_nxt     = v_r;
    rem_nxt   = rem_r;
    dq_nxt    = dq_r;
    dr_nxt    = dr_r;
    eos_nxt   = eos_r;
    cnt_nxt   = cnt_r;
    sh_nxt    = sh_r;
    ov_nxt    = ov_r && !out_tready;
    od_nxt    = od_r;
    ol_nxt    = ol_r;
    pop       = 1'b0;

    unique case (state_r)
      ipdm_pkg::BE_IDLE: begin
        if (!empty) begin
          pop       = 1'b1;
          v_nxt     = pop_data.a;
          dq_nxt    = pop_data.dq;
          dr_nxt    = pop_data.dr[R_W-1:0];
          eos_nxt   = pop_data.eos;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ipdm_pkg::BE_RUN;
        end
      end
      ipdm_pkg::BE_RUN: begin
        inner_nxt = inner_sat;
        outer_nxt = outer_sat;
        q_nxt     = bit_q;
        sh_nxt    = {bit_q, sh_r[UPSAMPLE_RATIO-1:1]};
        v_nxt     = v_sum[ipdm_pkg::LEVEL_W-1:0];
        rem_nxt   = carry ? rem_sub[R_W-1:0] : rem_sum[R_W-1:0];
        cnt_nxt   = cnt_r + R_W'(1);
        if (cnt_r == R_W'(UPSAMPLE_RATIO - 1)) begin
          if (eos_r) begin
            inner_nxt = '0;
            outer_nxt = '0;
            q_nxt     = 1'b0;
          end
          if (out_free) begin
            ov_nxt    = 1'b1;
            od_nxt    = ipdm_pkg::PDM_W'(sh_nxt);
            ol_nxt    = eos_r;
            state_nxt = ipdm_pkg::BE_IDLE;
          end else begin
            state_nxt = ipdm_pkg::BE_HOLD;
          end
        end
      end
      ipdm_pkg::BE_HOLD: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          od_nxt    = ipdm_pkg::PDM_W'(sh_r);
          ol_nxt    = eos_r;
          state_nxt = ipdm_pkg::BE_IDLE;
        end
      end
      default: begin
        state_nxt = ipdm_pkg::BE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ipdm_pkg::BE_IDLE;
      inner_r <= '0;
      outer_r <= '0;
      q_r     <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      inner_r <= inner_nxt;
      outer_r <= outer_nxt;
      q_r     <= q_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    dr_r  <= dr_nxt;
    eos_r <= eos_nxt;
    cnt_r <= cnt_nxt;
    sh_r  <= sh_nxt;
    od_r  <= od_nxt;
    ol_r  <= ol_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

endmodule
